>>> rtl/dtw_pkg.sv
`timescale 1ns / 1ps
// types, constants and helpers shared by the direction-to-world transform
// no dependencies
package dtw_pkg;

    localparam int unsigned QW = 32;

    typedef logic signed [QW-1:0] t_q;

    typedef struct packed {
        t_q x;
        t_q y;
        t_q z;
    } t_vec;

    typedef struct packed {
        logic       op;
        logic [3:0] idx;
        t_q         val;
        t_q         pos_x;
        t_q         pos_y;
        t_q         pos_z;
        t_q         scale;
    } t_ctx;

    // carried alongside the direction length search
    typedef struct packed {
        t_ctx ctx;
        t_vec d;
    } t_tag_a;

    // carried alongside the direction divide
    typedef struct packed {
        t_ctx       ctx;
        logic       skip;
        logic [2:0] neg;
    } t_tag_b;

    // carried through the right vector normalisation
    typedef struct packed {
        t_ctx ctx;
        logic skip;
        t_vec u;
        t_vec r;
    } t_tag_c;

    typedef logic [3:0][3:0][QW-1:0] t_mat;

    // one transaction handed to the row unit
    typedef struct packed {
        logic       op;
        logic [3:0] idx;
        t_q         val;
        logic       skip;
        t_mat       world;
    } t_job;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    function automatic t_q sat32(input logic signed [63:0] v);
        t_q res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[QW-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [63:0] mul32(input t_q a, input t_q b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = 64'(a);
        eb = 64'(b);
        return ea * eb;
    endfunction

    function automatic logic [QW-1:0] mag32(input t_q v);
        return v[QW-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

>>> rtl/direction_to_world_view_proj_top.sv
`timescale 1ns / 1ps
// Direction to world-view-projection transform. A load transaction (opcode 0) writes one element
// of the stored 4x4 view-projection matrix, in order with the draws around it, and gives no
// result. A draw transaction (opcode 1) builds an orthonormal basis from the direction, scales
// it, adds the translation and multiplies by the stored matrix, giving four row results, or one
// skipped result when the direction is too short. All values are signed fixed point with
// FRAC_BITS fraction bits. A new transaction can enter every cycle unless o_stall is high; the
// row unit issues one result per cycle unless the output stalls, and holds the pipeline while a
// draw steps through its four rows. On the way to the row unit a draw passes through two
// 32-stage square roots and two (32+FRAC_BITS) stage dividers, among other registers.
// Back-pressure on the output stalls the whole pipeline.
// Depends on dtw_pkg, dtw_isqrt, dtw_div and dtw_row.
module direction_to_world_view_proj_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [3:0]  i_element_index,
    input  dtw_pkg::t_q i_element_value,
    input  dtw_pkg::t_q i_dir_x,
    input  dtw_pkg::t_q i_dir_y,
    input  dtw_pkg::t_q i_dir_z,
    input  dtw_pkg::t_q i_pos_x,
    input  dtw_pkg::t_q i_pos_y,
    input  dtw_pkg::t_q i_pos_z,
    input  dtw_pkg::t_q i_scale,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_row_index,
    output dtw_pkg::t_q o_col0,
    output dtw_pkg::t_q o_col1,
    output dtw_pkg::t_q o_col2,
    output dtw_pkg::t_q o_col3,
    output logic        o_skipped,
    output logic        o_last
);
    import dtw_pkg::*;

    localparam int unsigned NUM_W = 32 + FRAC_BITS;
    localparam int EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam logic [31:0] LEN_EPS = 32'((EPS_RAW < 1) ? 1 : EPS_RAW);
    localparam logic [31:0] AXIS_LIM = 32'((99 * (1 << FRAC_BITS) + 50) / 100);
    localparam t_q Q_ONE = 32'(1 << FRAC_BITS);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    function automatic logic signed [63:0] qrnd(input logic signed [63:0] p);
        return (p + HALF) >>> FRAC_BITS;
    endfunction

    logic en;

    // input register
    logic   r_s0_vld;
    t_tag_a r_s0_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_tag.ctx.op    <= i_opcode;
            r_s0_tag.ctx.idx   <= i_element_index;
            r_s0_tag.ctx.val   <= i_element_value;
            r_s0_tag.ctx.pos_x <= i_pos_x;
            r_s0_tag.ctx.pos_y <= i_pos_y;
            r_s0_tag.ctx.pos_z <= i_pos_z;
            r_s0_tag.ctx.scale <= i_scale;
            r_s0_tag.d.x       <= i_dir_x;
            r_s0_tag.d.y       <= i_dir_y;
            r_s0_tag.d.z       <= i_dir_z;
        end
    end

    // squared length of the direction
    logic        r_s1_vld;
    t_tag_a      r_s1_tag;
    logic [63:0] r_s1_sq [3];
    logic        r_s2_vld;
    t_tag_a      r_s2_tag;
    logic [63:0] r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_tag   <= r_s0_tag;
            r_s1_sq[0] <= mul32(r_s0_tag.d.x, r_s0_tag.d.x);
            r_s1_sq[1] <= mul32(r_s0_tag.d.y, r_s0_tag.d.y);
            r_s1_sq[2] <= mul32(r_s0_tag.d.z, r_s0_tag.d.z);
            r_s2_tag   <= r_s1_tag;
            r_s2_sum   <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
        end
    end

    logic        a_vld;
    logic [31:0] a_len;
    t_tag_a      a_tag;

    dtw_isqrt #(
        .IN_W (64),
        .TW   ($bits(t_tag_a))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_rad   (r_s2_sum),
        .i_tag   (r_s2_tag),
        .o_valid (a_vld),
        .o_root  (a_len),
        .o_tag   (a_tag)
    );

    // short direction check and divide set-up
    logic             r_s3_vld;
    t_tag_b           r_s3_tag;
    logic [NUM_W-1:0] r_s3_num [3];
    logic [31:0]      r_s3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_tag.ctx  <= a_tag.ctx;
            r_s3_tag.skip <= (a_len < LEN_EPS);
            r_s3_tag.neg  <= {a_tag.d.z[31], a_tag.d.y[31], a_tag.d.x[31]};
            r_s3_num[0]   <= {mag32(a_tag.d.x), {FRAC_BITS{1'b0}}};
            r_s3_num[1]   <= {mag32(a_tag.d.y), {FRAC_BITS{1'b0}}};
            r_s3_num[2]   <= {mag32(a_tag.d.z), {FRAC_BITS{1'b0}}};
            r_s3_den      <= a_len;
        end
    end

    logic             b_vld;
    logic [NUM_W-1:0] b_quo [3];
    t_tag_b           b_tag;

    dtw_div #(
        .NUM_W (NUM_W),
        .DEN_W (32),
        .TW    ($bits(t_tag_b))
    ) u_dir_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_vld),
        .i_num   (r_s3_num),
        .i_den   (r_s3_den),
        .i_tag   (r_s3_tag),
        .o_valid (b_vld),
        .o_quo   (b_quo),
        .o_tag   (b_tag)
    );

    // up = -direction, then the helper axis cross product
    t_q b_ux;
    t_q b_uy;
    t_q b_uz;

    assign b_ux = b_tag.neg[0] ? b_quo[0][31:0] : -b_quo[0][31:0];
    assign b_uy = b_tag.neg[1] ? b_quo[1][31:0] : -b_quo[1][31:0];
    assign b_uz = b_tag.neg[2] ? b_quo[2][31:0] : -b_quo[2][31:0];

    logic        r_s4_vld;
    t_tag_c      r_s4_tag;
    logic        r_s5_vld;
    t_tag_c      r_s5_tag;
    logic [63:0] r_s5_sq [3];
    logic        r_s6_vld;
    t_tag_c      r_s6_tag;
    logic [63:0] r_s6_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= b_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_tag.ctx  <= b_tag.ctx;
            r_s4_tag.skip <= b_tag.skip;
            r_s4_tag.u.x  <= b_ux;
            r_s4_tag.u.y  <= b_uy;
            r_s4_tag.u.z  <= b_uz;
            if (mag32(b_uy) < AXIS_LIM) begin
                r_s4_tag.r.x <= b_uz;
                r_s4_tag.r.y <= '0;
                r_s4_tag.r.z <= -b_ux;
            end else begin
                r_s4_tag.r.x <= -b_uy;
                r_s4_tag.r.y <= b_ux;
                r_s4_tag.r.z <= '0;
            end
            r_s5_tag   <= r_s4_tag;
            r_s5_sq[0] <= mul32(r_s4_tag.r.x, r_s4_tag.r.x);
            r_s5_sq[1] <= mul32(r_s4_tag.r.y, r_s4_tag.r.y);
            r_s5_sq[2] <= mul32(r_s4_tag.r.z, r_s4_tag.r.z);
            r_s6_tag   <= r_s5_tag;
            r_s6_sum   <= r_s5_sq[0] + r_s5_sq[1] + r_s5_sq[2];
        end
    end

    logic        c_vld;
    logic [31:0] c_len;
    t_tag_c      c_tag;

    dtw_isqrt #(
        .IN_W (64),
        .TW   ($bits(t_tag_c))
    ) u_right_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_vld),
        .i_rad   (r_s6_sum),
        .i_tag   (r_s6_tag),
        .o_valid (c_vld),
        .o_root  (c_len),
        .o_tag   (c_tag)
    );

    logic             r_s7_vld;
    t_tag_c           r_s7_tag;
    logic [NUM_W-1:0] r_s7_num [3];
    logic [31:0]      r_s7_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (en) begin
            r_s7_vld <= c_vld;
        end
    end

    // a zero right length only comes from quantisation; divide by one then
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_tag    <= c_tag;
            r_s7_num[0] <= {mag32(c_tag.r.x), {FRAC_BITS{1'b0}}};
            r_s7_num[1] <= {mag32(c_tag.r.y), {FRAC_BITS{1'b0}}};
            r_s7_num[2] <= {mag32(c_tag.r.z), {FRAC_BITS{1'b0}}};
            r_s7_den    <= (c_len == '0) ? 32'd1 : c_len;
        end
    end

    logic             d_vld;
    logic [NUM_W-1:0] d_quo [3];
    t_tag_c           d_tag;

    dtw_div #(
        .NUM_W (NUM_W),
        .DEN_W (32),
        .TW    ($bits(t_tag_c))
    ) u_right_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s7_vld),
        .i_num   (r_s7_num),
        .i_den   (r_s7_den),
        .i_tag   (r_s7_tag),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_tag   (d_tag)
    );

    // normalised right vector, then cross product and scaling
    logic               r_s8_vld;
    t_tag_c             r_s8_tag;
    logic               r_s9_vld;
    t_ctx               r_s9_ctx;
    logic               r_s9_skip;
    logic signed [63:0] r_s9_p [12];
    logic               r_s10_vld;
    t_ctx               r_s10_ctx;
    logic               r_s10_skip;
    t_vec               r_s10_f;
    t_q                 r_s10_w [6];
    logic               r_s11_vld;
    t_ctx               r_s11_ctx;
    logic               r_s11_skip;
    logic signed [63:0] r_s11_p [3];
    t_q                 r_s11_w [6];
    logic               r_s12_vld;
    t_job               r_s12_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
        end else if (en) begin
            r_s8_vld  <= d_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_tag.ctx  <= d_tag.ctx;
            r_s8_tag.skip <= d_tag.skip;
            r_s8_tag.u    <= d_tag.u;
            r_s8_tag.r.x  <= d_tag.r.x[31] ? -d_quo[0][31:0] : d_quo[0][31:0];
            r_s8_tag.r.y  <= d_tag.r.y[31] ? -d_quo[1][31:0] : d_quo[1][31:0];
            r_s8_tag.r.z  <= d_tag.r.z[31] ? -d_quo[2][31:0] : d_quo[2][31:0];

            r_s9_ctx   <= r_s8_tag.ctx;
            r_s9_skip  <= r_s8_tag.skip;
            r_s9_p[0]  <= mul32(r_s8_tag.u.y, r_s8_tag.r.z);
            r_s9_p[1]  <= mul32(r_s8_tag.u.z, r_s8_tag.r.y);
            r_s9_p[2]  <= mul32(r_s8_tag.u.z, r_s8_tag.r.x);
            r_s9_p[3]  <= mul32(r_s8_tag.u.x, r_s8_tag.r.z);
            r_s9_p[4]  <= mul32(r_s8_tag.u.x, r_s8_tag.r.y);
            r_s9_p[5]  <= mul32(r_s8_tag.u.y, r_s8_tag.r.x);
            r_s9_p[6]  <= mul32(r_s8_tag.r.x, r_s8_tag.ctx.scale);
            r_s9_p[7]  <= mul32(r_s8_tag.u.x, r_s8_tag.ctx.scale);
            r_s9_p[8]  <= mul32(r_s8_tag.r.y, r_s8_tag.ctx.scale);
            r_s9_p[9]  <= mul32(r_s8_tag.u.y, r_s8_tag.ctx.scale);
            r_s9_p[10] <= mul32(r_s8_tag.r.z, r_s8_tag.ctx.scale);
            r_s9_p[11] <= mul32(r_s8_tag.u.z, r_s8_tag.ctx.scale);

            r_s10_ctx  <= r_s9_ctx;
            r_s10_skip <= r_s9_skip;
            r_s10_f.x  <= sat32(qrnd(r_s9_p[0]) - qrnd(r_s9_p[1]));
            r_s10_f.y  <= sat32(qrnd(r_s9_p[2]) - qrnd(r_s9_p[3]));
            r_s10_f.z  <= sat32(qrnd(r_s9_p[4]) - qrnd(r_s9_p[5]));
            for (int w = 0; w < 6; w++) begin
                r_s10_w[w] <= sat32(qrnd(r_s9_p[w+6]));
            end

            r_s11_ctx  <= r_s10_ctx;
            r_s11_skip <= r_s10_skip;
            r_s11_p[0] <= mul32(r_s10_f.x, r_s10_ctx.scale);
            r_s11_p[1] <= mul32(r_s10_f.y, r_s10_ctx.scale);
            r_s11_p[2] <= mul32(r_s10_f.z, r_s10_ctx.scale);
            r_s11_w    <= r_s10_w;

            r_s12_job.op          <= r_s11_ctx.op;
            r_s12_job.idx         <= r_s11_ctx.idx;
            r_s12_job.val         <= r_s11_ctx.val;
            r_s12_job.skip        <= r_s11_skip;
            r_s12_job.world[0][0] <= r_s11_w[0];
            r_s12_job.world[0][1] <= r_s11_w[1];
            r_s12_job.world[0][2] <= sat32(qrnd(r_s11_p[0]));
            r_s12_job.world[0][3] <= '0;
            r_s12_job.world[1][0] <= r_s11_w[2];
            r_s12_job.world[1][1] <= r_s11_w[3];
            r_s12_job.world[1][2] <= sat32(qrnd(r_s11_p[1]));
            r_s12_job.world[1][3] <= '0;
            r_s12_job.world[2][0] <= r_s11_w[4];
            r_s12_job.world[2][1] <= r_s11_w[5];
            r_s12_job.world[2][2] <= sat32(qrnd(r_s11_p[2]));
            r_s12_job.world[2][3] <= '0;
            r_s12_job.world[3][0] <= r_s11_ctx.pos_x;
            r_s12_job.world[3][1] <= r_s11_ctx.pos_y;
            r_s12_job.world[3][2] <= r_s11_ctx.pos_z;
            r_s12_job.world[3][3] <= Q_ONE;
        end
    end

    dtw_row #(
        .FRAC_BITS (FRAC_BITS)
    ) u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_vld   (r_s12_vld),
        .i_job       (r_s12_job),
        .o_take      (en),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_row_index (o_row_index),
        .o_col0      (o_col0),
        .o_col1      (o_col1),
        .o_col2      (o_col2),
        .o_col3      (o_col3),
        .o_skipped   (o_skipped),
        .o_last      (o_last)
    );

    assign o_stall = !en;

endmodule

>>> rtl/dtw_isqrt.sv
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage, with a carried tag
// no package dependencies
module dtw_isqrt #(
    parameter int unsigned IN_W = 64,
    parameter int unsigned TW   = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [TW-1:0]     i_tag,
    output logic              o_valid,
    output logic [IN_W/2-1:0] o_root,
    output logic [TW-1:0]     o_tag
);
    localparam int unsigned N  = IN_W / 2;
    localparam int unsigned RW = N + 2;

    logic [N:1]      r_vld;
    logic [IN_W-1:0] r_rad  [1:N];
    logic [RW-1:0]   r_rem  [1:N];
    logic [N-1:0]    r_root [1:N];
    logic [TW-1:0]   r_tag  [1:N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic            vld_in;
        logic [IN_W-1:0] rad_in;
        logic [RW-1:0]   rem_in;
        logic [N-1:0]    root_in;
        logic [TW-1:0]   tag_in;
        logic [RW-1:0]   rem_sh;
        logic [RW-1:0]   trial;

        if (g == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign vld_in  = r_vld[g];
            assign rad_in  = r_rad[g];
            assign rem_in  = r_rem[g];
            assign root_in = r_root[g];
            assign tag_in  = r_tag[g];
        end

        assign rem_sh = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g+1] <= {rad_in[IN_W-3:0], 2'b00};
                r_tag[g+1] <= tag_in;
                if (rem_sh >= trial) begin
                    r_rem[g+1]  <= rem_sh - trial;
                    r_root[g+1] <= {root_in[N-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= rem_sh;
                    r_root[g+1] <= {root_in[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_root  = r_root[N];
    assign o_tag   = r_tag[N];

endmodule

>>> rtl/dtw_div.sv
`timescale 1ns / 1ps
// pipelined three-lane restoring divider sharing one divisor, with a carried tag
// no package dependencies
module dtw_div #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 32,
    parameter int unsigned TW    = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num [3],
    input  logic [DEN_W-1:0] i_den,
    input  logic [TW-1:0]    i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo [3],
    output logic [TW-1:0]    o_tag
);
    logic [NUM_W:1]   r_vld;
    logic [DEN_W-1:0] r_den [1:NUM_W];
    logic [TW-1:0]    r_tag [1:NUM_W];
    logic [NUM_W-1:0] r_num [1:NUM_W][3];
    logic [DEN_W-1:0] r_rem [1:NUM_W][3];
    logic [NUM_W-1:0] r_quo [1:NUM_W][3];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic             vld_in;
        logic [DEN_W-1:0] den_in;
        logic [TW-1:0]    tag_in;
        logic [NUM_W-1:0] num_in [3];
        logic [DEN_W-1:0] rem_in [3];
        logic [NUM_W-1:0] quo_in [3];
        logic [DEN_W:0]   rem_sh [3];
        logic [2:0]       ge;

        if (g == 0) begin : g_first
            assign vld_in = i_valid;
            assign den_in = i_den;
            assign tag_in = i_tag;
            assign num_in = i_num;
            assign rem_in = '{'0, '0, '0};
            assign quo_in = '{'0, '0, '0};
        end else begin : g_next
            assign vld_in = r_vld[g];
            assign den_in = r_den[g];
            assign tag_in = r_tag[g];
            assign num_in = r_num[g];
            assign rem_in = r_rem[g];
            assign quo_in = r_quo[g];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                rem_sh[l] = {rem_in[l], num_in[l][NUM_W-1]};
                ge[l]     = (rem_sh[l] >= {1'b0, den_in});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1] <= den_in;
                r_tag[g+1] <= tag_in;
                for (int l = 0; l < 3; l++) begin
                    r_num[g+1][l] <= {num_in[l][NUM_W-2:0], 1'b0};
                    r_quo[g+1][l] <= {quo_in[l][NUM_W-2:0], ge[l]};
                    if (ge[l]) begin
                        r_rem[g+1][l] <= DEN_W'(rem_sh[l] - {1'b0, den_in});
                    end else begin
                        r_rem[g+1][l] <= rem_sh[l][DEN_W-1:0];
                    end
                end
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_quo[NUM_W];
    assign o_tag   = r_tag[NUM_W];

endmodule

>>> rtl/dtw_row.sv
`timescale 1ns / 1ps
// row unit: holds the view-projection matrix, steps through the world rows,
// multiplies and sums one combined row per cycle while the output is not stalled; depends on dtw_pkg
module dtw_row #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_vld,
    input  dtw_pkg::t_job i_job,
    output logic          o_take,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_row_index,
    output dtw_pkg::t_q   o_col0,
    output dtw_pkg::t_q   o_col1,
    output dtw_pkg::t_q   o_col2,
    output dtw_pkg::t_q   o_col3,
    output logic          o_skipped,
    output logic          o_last
);
    import dtw_pkg::*;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic       r_s_vld;
    t_job       r_s_job;
    logic [1:0] r_s_row;
    t_q         r_vp [16];

    logic               r_m_vld;
    logic [1:0]         r_m_row;
    logic               r_m_skip;
    logic               r_m_last;
    logic signed [63:0] r_m_prod [4][4];

    logic       r_o_vld;
    logic [1:0] r_o_row;
    t_q         r_o_col [4];
    logic       r_o_skip;
    logic       r_o_last;

    logic t_en;
    logic s_load;
    logic s_skip;
    logic s_done;
    logic en;
    t_q   n_col [4];

    assign t_en   = !(r_o_vld && i_stall);
    assign s_load = (r_s_job.op == OP_LOAD);
    assign s_skip = (r_s_job.op == OP_DRAW) && r_s_job.skip;
    assign s_done = s_load || s_skip || (r_s_row == 2'd3);
    assign en     = !r_s_vld || (t_en && s_done);
    assign o_take = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_s_row <= 2'd0;
        end else if (en) begin
            r_s_vld <= i_job_vld;
            r_s_row <= 2'd0;
        end else if (t_en) begin
            r_s_row <= r_s_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < 16; e++) begin
                r_vp[e] <= '0;
            end
        end else if (r_s_vld && t_en && s_load) begin
            r_vp[r_s_job.idx] <= r_s_job.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (t_en) begin
            r_m_vld <= r_s_vld && !s_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_en) begin
            r_m_row  <= s_skip ? 2'd0 : r_s_row;
            r_m_skip <= s_skip;
            r_m_last <= s_skip || (r_s_row == 2'd3);
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 4; j++) begin
                    r_m_prod[k][j] <= mul32($signed(r_s_job.world[r_s_row][k]), r_vp[k*4+j]);
                end
            end
        end
    end

    // each product rounded on its own before the column sum
    always_comb begin
        logic signed [63:0] acc;
        for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                acc = acc + ((r_m_prod[k][j] + HALF) >>> FRAC_BITS);
            end
            n_col[j] = r_m_skip ? '0 : sat32(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (t_en) begin
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_en) begin
            r_o_row  <= r_m_row;
            r_o_col  <= n_col;
            r_o_skip <= r_m_skip;
            r_o_last <= r_m_last;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_row_index = r_o_row;
    assign o_col0      = r_o_col[0];
    assign o_col1      = r_o_col[1];
    assign o_col2      = r_o_col[2];
    assign o_col3      = r_o_col[3];
    assign o_skipped   = r_o_skip;
    assign o_last      = r_o_last;

endmodule

>>> rtl/dtw_checker.sv
`timescale 1ns / 1ps
// port-level checks on the result channel of the transform top level
// bound to direction_to_world_view_proj_top; depends on dtw_pkg
module dtw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_valid,
    input logic [1:0]  o_row_index,
    input dtw_pkg::t_q o_col0,
    input dtw_pkg::t_q o_col1,
    input dtw_pkg::t_q o_col2,
    input dtw_pkg::t_q o_col3,
    input logic        o_skipped,
    input logic        o_last
);
    // a stalled result stays valid and keeps its row index, first and last columns and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_row_index) && $stable(o_col0)
            && $stable(o_col3) && $stable(o_last))
        else $error("stalled result changed");

    // a skipped result is a lone zero row 0
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skipped |-> o_last && o_row_index == 2'd0 && o_col0 == '0
            && o_col1 == '0 && o_col2 == '0 && o_col3 == '0)
        else $error("bad skipped result");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_skipped |-> (o_last == (o_row_index == 2'd3)))
        else $error("last flag not on row 3");

    // rows of one draw follow back to back
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=>
            o_valid && o_row_index == 2'($past(o_row_index) + 2'd1))
        else $error("row sequence broken");

endmodule

bind direction_to_world_view_proj_top dtw_checker u_dtw_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for direction_to_world_view_proj_top
// depends on dtw_pkg and the transform rtl; predicts every row in fixed point
module testbench;
    import dtw_pkg::*;

    localparam int  FRAC      = 16;
    localparam longint Q_ONE  = longint'(1) << FRAC;
    localparam longint Q_HALF = longint'(1) << (FRAC - 1);
    localparam longint Q_AXIS = (99 * Q_ONE + 50) / 100;
    localparam longint Q_EPS0 = (Q_ONE + 5000) / 10000;
    localparam longint Q_EPS  = (Q_EPS0 < 1) ? 1 : Q_EPS0;
    localparam int  N_RANDOM   = 200;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  DRAIN      = 250;

    typedef struct packed {
        logic [1:0] row;
        t_q         c0;
        t_q         c1;
        t_q         c2;
        t_q         c3;
        logic       skip;
        logic       last;
    } t_row_exp;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic i_opcode;
    logic [3:0] i_element_index;
    t_q i_element_value, i_dir_x, i_dir_y, i_dir_z, i_pos_x, i_pos_y, i_pos_z, i_scale;
    logic o_valid;
    logic i_stall;
    logic [1:0] o_row_index;
    t_q o_col0, o_col1, o_col2, o_col3;
    logic o_skipped;
    logic o_last;

    t_q       vp_model [16];
    t_row_exp rows_due [$];
    int       mismatches;
    int       idle_cycles;
    int       stall_left;
    bit       quiet;

    direction_to_world_view_proj_top #(.FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_element_index(i_element_index),
        .i_element_value(i_element_value), .i_dir_x(i_dir_x), .i_dir_y(i_dir_y),
        .i_dir_z(i_dir_z), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_scale(i_scale), .o_valid(o_valid), .i_stall(i_stall),
        .o_row_index(o_row_index), .o_col0(o_col0), .o_col1(o_col1), .o_col2(o_col2),
        .o_col3(o_col3), .o_skipped(o_skipped), .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_q clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // rounded product, ties toward +inf
    function automatic longint qprod(input longint a, input longint b);
        longint q;
        q = a * b + Q_HALF;
        return q >>> FRAC;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // works out the rows a draw yields against the current matrix
    task automatic predict_draw(input t_q ax, input t_q ay, input t_q az, input t_q px,
                                input t_q py, input t_q pz, input t_q sc);
        longint dx, dy, dz, ux, uy, uz, rx, ry, rz, fx, fy, fz, s, acc;
        longint unsigned len, rlen;
        longint w [4][4];
        t_row_exp e;
        t_q col [4];
        dx = ax; dy = ay; dz = az;
        len = root64(longint'(unsigned'(dx * dx)) + longint'(unsigned'(dy * dy))
                     + longint'(unsigned'(dz * dz)));
        if (len < longint'(Q_EPS)) begin
            e = '{row: 2'd0, c0: 0, c1: 0, c2: 0, c3: 0, skip: 1'b1, last: 1'b1};
            rows_due.insert(rows_due.size(), e);
            return;
        end
        ux = -((dx * Q_ONE) / longint'(len));
        uy = -((dy * Q_ONE) / longint'(len));
        uz = -((dz * Q_ONE) / longint'(len));
        if ((uy < 0 ? -uy : uy) < Q_AXIS) begin
            rx = uz; ry = 0; rz = -ux;
        end else begin
            rx = -uy; ry = ux; rz = 0;
        end
        rlen = root64(rx * rx + ry * ry + rz * rz);
        if (rlen == 0) rlen = 1;
        rx = (rx * Q_ONE) / longint'(rlen);
        ry = (ry * Q_ONE) / longint'(rlen);
        rz = (rz * Q_ONE) / longint'(rlen);
        fx = clamp32(qprod(uy, rz) - qprod(uz, ry));
        fy = clamp32(qprod(uz, rx) - qprod(ux, rz));
        fz = clamp32(qprod(ux, ry) - qprod(uy, rx));
        s = sc;
        w[0][0] = clamp32(qprod(rx, s)); w[0][1] = clamp32(qprod(ux, s));
        w[0][2] = clamp32(qprod(fx, s)); w[0][3] = 0;
        w[1][0] = clamp32(qprod(ry, s)); w[1][1] = clamp32(qprod(uy, s));
        w[1][2] = clamp32(qprod(fy, s)); w[1][3] = 0;
        w[2][0] = clamp32(qprod(rz, s)); w[2][1] = clamp32(qprod(uz, s));
        w[2][2] = clamp32(qprod(fz, s)); w[2][3] = 0;
        w[3][0] = px; w[3][1] = py; w[3][2] = pz; w[3][3] = clamp32(Q_ONE);
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += qprod(w[i][k], longint'(vp_model[k*4+j]));
                col[j] = clamp32(acc);
            end
            e = '{row: 2'(i), c0: col[0], c1: col[1], c2: col[2], c3: col[3],
                  skip: 1'b0, last: (i == 3)};
            rows_due.insert(rows_due.size(), e);
        end
    endtask

    // drives one transaction at the falling edge and holds it until taken
    task automatic send_item(input logic op, input logic [3:0] idx, input t_q val,
                             input t_q ax, input t_q ay, input t_q az, input t_q px,
                             input t_q py, input t_q pz, input t_q sc);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode = op; i_element_index = idx; i_element_value = val;
        i_dir_x = ax; i_dir_y = ay; i_dir_z = az;
        i_pos_x = px; i_pos_y = py; i_pos_z = pz; i_scale = sc;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_LOAD) vp_model[idx] = val;
        else predict_draw(ax, ay, az, px, py, pz, sc);
        @(negedge i_clk);
    endtask

    task automatic load_elem(input logic [3:0] idx, input t_q val);
        send_item(OP_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    task automatic draw(input t_q ax, input t_q ay, input t_q az, input t_q px,
                        input t_q py, input t_q pz, input t_q sc);
        send_item(OP_DRAW, 4'($urandom), $urandom, ax, ay, az, px, py, pz, sc);
    endtask

    function automatic t_q rand_q();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return t_q'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return t_q'($urandom_range(0, 16)) - 8;
            default: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
        endcase
    endfunction

    // identity matrix, then the basis branches, short directions and extremes
    task automatic test_directed();
        for (int i = 0; i < 16; i++) load_elem(4'(i), (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0);
        draw(0, -32'sh0001_0000, 0, 32'sh0002_0000, 0, -32'sh0001_0000, 32'sh0001_0000);
        draw(32'sh0001_0000, 0, 0, 0, 0, 0, 32'sh0001_0000);
        draw(0, 0, 0, 1, 2, 3, 32'sh0001_0000);
        draw(6, 0, 0, 0, 0, 0, 32'sh0001_0000);
        draw(7, 0, 0, 0, 0, 0, 32'sh0001_0000);
        draw(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        draw(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        draw(3, 32'sh7FFF_FFFF, 5, 0, 0, 0, 32'sh8000_0000);
    endtask

    task automatic test_random();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                load_elem(4'($urandom), ($urandom_range(0, 2) == 0) ? $urandom : rand_q());
            end else if ($urandom_range(0, 4) == 0) begin
                // mostly along y so the z-axis cross is taken
                draw(t_q'($urandom_range(0, 2000)) - 1000, rand_q() | 32'sh0010_0000,
                     t_q'($urandom_range(0, 2000)) - 1000, rand_q(), rand_q(), rand_q(),
                     rand_q());
            end else begin
                draw(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
            end
        end
        quiet = 1'b0;
    endtask

    // receiver stall per result
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_row_exp e;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left <= quiet ? 0 : $urandom_range(0, 13);
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected row %0d at %0t", o_row_index, $time);
            end else begin
                e = rows_due.pop_front();
                if (e.row !== o_row_index || e.c0 !== o_col0 || e.c1 !== o_col1
                    || e.c2 !== o_col2 || e.c3 !== o_col3 || e.skip !== o_skipped
                    || e.last !== o_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch exp r%0d %h %h %h %h s%b l%b",
                                 e.row, e.c0, e.c1, e.c2, e.c3, e.skip, e.last,
                                 " got r%0d %h %h %h %h s%b l%b", o_row_index,
                                 o_col0, o_col1, o_col2, o_col3, o_skipped, o_last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        mismatches = 0; idle_cycles = 0; stall_left = 0; quiet = 1'b0;
        for (int i = 0; i < 16; i++) vp_model[i] = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_opcode = 1'b0;
        i_element_index = 0; i_element_value = 0; i_dir_x = 0; i_dir_y = 0; i_dir_z = 0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0; i_scale = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        i_valid = 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
